>>> hw/rtl/frc_pkg.sv
package frc_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE_RULE  = 2'd0,
    CMD_WRITE_DEF   = 2'd1,
    CMD_CLASSIFY    = 2'd2,
    CMD_CLEAR_COUNT = 2'd3
  } cmd_t;

  localparam logic [2:0] VERDICT_LOG = 3'd3;
  localparam logic [7:0] SYN_ONLY = 8'h02;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  chain;
    logic [3:0]  rule_index;
    logic [1:0]  word_select;
    logic [63:0] word_data;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  flag_byte;
    logic        established;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        rule_hit;
    logic [3:0]  hit_index;
    logic        logged;
    logic [31:0] nat_addr;
    logic [15:0] xlat_port;
    logic [31:0] chain_packets;
  } out_item_t;

  // Packet fields that the rule matcher compares against.
  typedef struct packed {
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  flag_byte;
    logic        established;
  } pkt_t;

endpackage

>>> hw/rtl/frc_if.sv
interface frc_in_if;
  logic valid;
  logic ready;
  logic [1:0]  cmd;
  logic [2:0]  chain;
  logic [3:0]  rule_index;
  logic [1:0]  word_select;
  logic [63:0] word_data;
  logic [7:0]  protocol;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  flag_byte;
  logic        established;
  modport source (output valid, cmd, chain, rule_index, word_select, word_data, protocol,
                  src_port, dst_port, src_addr, dst_addr, flag_byte, established,
                  input ready);
  modport sink (input valid, cmd, chain, rule_index, word_select, word_data, protocol,
                src_port, dst_port, src_addr, dst_addr, flag_byte, established,
                output ready);
endinterface

interface frc_out_if;
  logic valid;
  logic ready;
  logic [2:0]  verdict;
  logic        rule_hit;
  logic [3:0]  hit_index;
  logic        logged;
  logic [31:0] nat_addr;
  logic [15:0] xlat_port;
  logic [31:0] chain_packets;
  modport source (output valid, verdict, rule_hit, hit_index, logged, nat_addr, xlat_port,
                  chain_packets, input ready);
  modport sink (input valid, verdict, rule_hit, hit_index, logged, nat_addr, xlat_port,
                chain_packets, output ready);
endinterface

>>> hw/rtl/firewall_rule_chain_classifier.sv
// Firewall rule-chain classifier.
// The input channel carries items of four kinds: a rule word write, a chain
// default write, a packet to classify and a counter clear. Every accepted item
// gives exactly one item on the output channel.
// Rules live in a memory with one 256-bit row (four words) per slot, so one
// slot is read per cycle. A classify item scans its chain from slot zero,
// reading one slot a cycle and checking it with one shared matcher; the scan
// stops at the first terminating match or at the chain's last slot. A classify
// result passes through the S_READ state, an S_SCAN step per slot examined and
// S_DONE, where it is registered; other items go from idle straight to S_DONE.
// The input reopens the cycle after the result is taken, so the block takes
// no new item while it is still working on or holding the last one.
// After reset the block first sweeps the rule memory, one slot a cycle, over
// all NUM_CHAINS * RULES_PER_CHAIN slots, zeroing every rule; no item is
// accepted meanwhile. Defaults and counters clear at once.
// The result sits in an output register until the receiver takes it; while
// the receiver stalls the block holds the result and accepts nothing new.
module firewall_rule_chain_classifier #(
  parameter int NUM_CHAINS      = 8,
  parameter int RULES_PER_CHAIN = 16
) (
  input logic clk,
  input logic rst,
  frc_in_if.sink    in_ch,
  frc_out_if.source out_ch
);
  localparam int SW = (RULES_PER_CHAIN > 1) ? $clog2(RULES_PER_CHAIN) : 1;
  localparam int CW = (NUM_CHAINS > 1) ? $clog2(NUM_CHAINS) : 1;
  localparam int DEPTH = NUM_CHAINS * RULES_PER_CHAIN;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_SCAN, S_DONE} state_t;
  state_t state;

  logic [255:0] mem [DEPTH];
  logic [255:0] rd_row;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rd_addr;

  logic [2:0]  defaults [NUM_CHAINS];
  logic [31:0] counts   [NUM_CHAINS];

  logic [1:0]     cmd;
  logic [CW-1:0]  chain;
  logic           chain_ok;
  logic [SW:0]    slot;      // slot being read
  logic [SW-1:0]  chk_slot;  // slot whose row is in rd_row
  frc_pkg::pkt_t  pkt;
  logic           logged;
  logic           match;

  frc_pkg::out_item_t res;
  logic out_valid;

  // Writes of a single word are read-modify-write free: each word has a lane.
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [1:0]     wr_word;
  logic [63:0]    wr_data;

  frc_match u_match (
    .w0(rd_row[63:0]), .w1(rd_row[127:64]), .w2(rd_row[191:128]), .w3(rd_row[255:192]),
    .pkt(pkt), .hit(match)
  );

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  logic in_chain_ok;
  assign in_chain_ok = (32'(in_ch.chain) < NUM_CHAINS);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_word = 2'd0;
    wr_data = 64'd0;
    if (accept && in_ch.cmd == frc_pkg::CMD_WRITE_RULE && in_chain_ok &&
        32'(in_ch.rule_index) < RULES_PER_CHAIN) begin
      wr_en = 1'b1;
      wr_addr = AW'(32'(in_ch.chain) * RULES_PER_CHAIN + 32'(in_ch.rule_index));
      wr_word = in_ch.word_select;
      wr_data = in_ch.word_data;
    end
  end

  // The clearing pass zeroes whole rows, so unwritten words read as zero.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      case (wr_word)
        2'd0:    mem[wr_addr][63:0]    <= wr_data;
        2'd1:    mem[wr_addr][127:64]  <= wr_data;
        2'd2:    mem[wr_addr][191:128] <= wr_data;
        default: mem[wr_addr][255:192] <= wr_data;
      endcase
    end
    rd_row <= mem[rd_addr];
  end

  assign rd_addr = AW'(32'(chain) * RULES_PER_CHAIN + 32'(slot[SW-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CHAINS; i++) begin
        defaults[i] <= 3'd0;
        counts[i] <= 32'd0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cmd <= in_ch.cmd;
            chain <= CW'(in_ch.chain);
            chain_ok <= in_chain_ok;
            slot <= '0;
            logged <= 1'b0;
            pkt <= '{in_ch.protocol, in_ch.src_port, in_ch.dst_port, in_ch.src_addr,
                     in_ch.dst_addr, in_ch.flag_byte, in_ch.established};
            if (in_chain_ok) begin
              if (in_ch.cmd == frc_pkg::CMD_WRITE_DEF)
                defaults[CW'(in_ch.chain)] <= in_ch.word_data[2:0];
              else if (in_ch.cmd == frc_pkg::CMD_CLEAR_COUNT)
                counts[CW'(in_ch.chain)] <= 32'd0;
            end
            state <= (in_chain_ok && in_ch.cmd == frc_pkg::CMD_CLASSIFY) ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          chk_slot <= slot[SW-1:0];
          slot <= slot + (SW+1)'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          chk_slot <= slot[SW-1:0];
          slot <= slot + (SW+1)'(1);
          if (match) begin
            if (counts[chain] != 32'hFFFF_FFFF) counts[chain] <= counts[chain] + 32'd1;
          end
          if (match && rd_row[61:59] != frc_pkg::VERDICT_LOG) begin
            res.verdict <= rd_row[61:59];
            res.rule_hit <= 1'b1;
            res.hit_index <= 4'(chk_slot);
            res.logged <= logged;
            res.nat_addr <= rd_row[255:224];
            res.xlat_port <= rd_row[223:208];
            state <= S_DONE;
          end else begin
            if (match) logged <= 1'b1;
            if (32'(chk_slot) == RULES_PER_CHAIN - 1) begin
              res.verdict <= defaults[chain];
              res.rule_hit <= 1'b0;
              res.hit_index <= 4'd0;
              res.logged <= logged || match;
              res.nat_addr <= 32'd0;
              res.xlat_port <= 16'd0;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            if (cmd != frc_pkg::CMD_CLASSIFY || !chain_ok) begin
              res.verdict <= 3'd0;
              res.rule_hit <= 1'b0;
              res.hit_index <= 4'd0;
              res.logged <= 1'b0;
              res.nat_addr <= 32'd0;
              res.xlat_port <= 16'd0;
            end
            res.chain_packets <= chain_ok ? counts[chain] : 32'd0;
            out_valid <= 1'b1;
          end else if (out_ch.ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.verdict = res.verdict;
  assign out_ch.rule_hit = res.rule_hit;
  assign out_ch.hit_index = res.hit_index;
  assign out_ch.logged = res.logged;
  assign out_ch.nat_addr = res.nat_addr;
  assign out_ch.xlat_port = res.xlat_port;
  assign out_ch.chain_packets = res.chain_packets;
endmodule

>>> hw/rtl/frc_match.sv
module frc_match (
  input  logic [63:0]   w0,
  input  logic [63:0]   w1,
  input  logic [63:0]   w2,
  input  logic [63:0]   w3,
  input  frc_pkg::pkt_t pkt,
  output logic          hit
);
  logic ok_proto, ok_dport, ok_sport, ok_src, ok_dst, ok_est, ok_new;

  always_comb begin
    ok_proto = (w0[7:0] == 8'd0) || (w0[7:0] == pkt.protocol);
    ok_dport = (w0[23:8] == 16'd0) ||
               ((pkt.dst_port >= w0[23:8]) && (pkt.dst_port <= w0[39:24]));
    ok_sport = (w0[55:40] == 16'd0) ||
               ((pkt.src_port >= w0[55:40]) && (pkt.src_port <= w3[15:0]));
    ok_src = (w1[31:0] == 32'd0) || ((pkt.src_addr & w1[63:32]) == (w1[31:0] & w1[63:32]));
    ok_dst = (w2[31:0] == 32'd0) || ((pkt.dst_addr & w2[63:32]) == (w2[31:0] & w2[63:32]));
    ok_est = !w0[56] || pkt.established;
    ok_new = !w0[57] || (pkt.flag_byte == frc_pkg::SYN_ONLY);
    hit = w0[58] && ok_proto && ok_dport && ok_sport && ok_src && ok_dst && ok_est && ok_new;
  end
endmodule

>>> hw/rtl/frc_checker.sv
module frc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic rule_hit,
  input logic [3:0] hit_index,
  input logic [2:0] verdict
);
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rule_hit |-> hit_index == 4'd0) else $error("index without hit");
  a_hit_not_log: assert property (@(posedge clk) disable iff (rst)
    out_valid && rule_hit |-> verdict != frc_pkg::VERDICT_LOG)
    else $error("log as terminating verdict");
endmodule

bind firewall_rule_chain_classifier frc_checker u_frc_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .rule_hit(out_ch.rule_hit),
  .hit_index(out_ch.hit_index), .verdict(out_ch.verdict)
);
